// ----- hw/rtl/bitmap_id_allocator_core_assert.svh -----
// assertion macros for the id allocator core
// used by bitmap_id_allocator_core; relies on clk and rst_n in the including scope
`ifndef BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BIDA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BIDA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bida_pkg.sv -----
// shared types and constants for the bitmap id allocator
// no dependencies
package bida_pkg;

    localparam int MAX_IDS   = 4096;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int MAP_WORDS = (MAX_IDS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ID_W      = 13;
    localparam int ST_W      = 2;
    localparam int LAST_BITS = MAX_IDS - (MAP_WORDS - 1) * WORD_W;

    // usable bits of the last map word
    localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} :
        ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [ST_W-1:0] STATUS_FULL        = 2'd1;
    localparam logic [ST_W-1:0] STATUS_BAD_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL_CHK,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

// ----- hw/rtl/bida_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module bida_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/bida_ffz.sv -----
// find-first-zero unit: lowest clear bit of one map word
// depends on bida_pkg
module bida_ffz
    import bida_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] mask,
    output logic              found,
    output logic [BIT_W-1:0]  idx,
    output logic [WORD_W-1:0] onehot
);

    logic [WORD_W-1:0] free_bits;

    // isolate lowest free bit with one wide add
    assign free_bits = ~word & mask;
    assign onehot    = free_bits & (~free_bits + WORD_W'(1));
    assign found     = |free_bits;

    // encode the one-hot position
    always_comb
    begin
        idx = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (onehot[b])
            begin
                idx = idx | BIT_W'(b);
            end
        end
    end

endmodule

// ----- hw/rtl/bitmap_id_allocator_core.sv -----
// Bitmap id allocator: hands out ids 1..MAX_IDS from a used-bit map held in a
// 64-word by 64-bit ram. An allocate scans the map one word per cycle through
// a single find-first-zero unit and stops at the first word that has a free
// bit, or after the last word when the pool is full. A release reads one word,
// checks and clears its bit; an out-of-range release answers without the map.
// A stalled earlier result in the output register delays the answer. One
// request is in flight at a time: req_stall stays high until the result has
// been loaded into the output register. Reset takes effect at once: a
// per-word valid flag makes every word read as all-free until it is first
// written, so there is no clearing pass.
// depends on bida_pkg, bida_ram, bida_ffz and bitmap_id_allocator_core_assert.svh
`include "bitmap_id_allocator_core_assert.svh"

module bitmap_id_allocator_core
    import bida_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic            op,
    input  logic [ID_W-1:0] release_id,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [ID_W-1:0] given_id,
    output logic [ST_W-1:0] status
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]    pend_w_reg, pend_w_next;
    logic [ADDR_W-1:0]    rel_w_reg, rel_w_next;
    logic [BIT_W-1:0]     rel_b_reg, rel_b_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [ST_W-1:0]      res_st_reg, res_st_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]      rsp_id_reg, rsp_id_next;
    logic [ST_W-1:0]      rsp_st_reg, rsp_st_next;
    logic [MAP_WORDS-1:0] row_vld_reg;
    logic                 q_vld_reg;

    logic                 req_take;
    logic                 rsp_free;
    logic                 rel_bad;
    logic [ID_W-1:0]      rel_idx;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    eff_word;
    logic [WORD_W-1:0]    ffz_mask;
    logic                 ffz_found;
    logic [BIT_W-1:0]     ffz_idx;
    logic [WORD_W-1:0]    ffz_onehot;
    logic [ADDR_W+BIT_W:0] alloc_sum;
    logic [WORD_W-1:0]    rel_bit;

    // handshake helpers
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign given_id  = rsp_id_reg;
    assign status    = rsp_st_reg;

    // release id decode
    assign rel_bad = (release_id == '0) || (32'(release_id) > 32'(MAX_IDS));
    assign rel_idx = release_id - ID_W'(1);

    // map storage
    bida_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // never-written words read as all free
    assign eff_word = q_vld_reg ? rd_data : '0;
    assign ffz_mask = (pend_w_reg == ADDR_W'(MAP_WORDS - 1)) ? LAST_MASK : '1;

    // single find-first-zero unit for the scan
    bida_ffz u_ffz (
        .word   (eff_word),
        .mask   (ffz_mask),
        .found  (ffz_found),
        .idx    (ffz_idx),
        .onehot (ffz_onehot)
    );

    assign alloc_sum = {1'b0, pend_w_reg, ffz_idx} + (ADDR_W + BIT_W + 1)'(1);
    assign rel_bit   = WORD_W'(1) << rel_b_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (op == OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (rel_bad)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_REL_CHK;
                    end
                end
            end
            ST_REL_CHK:
            begin
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (ffz_found || (addr_reg == CNT_W'(MAP_WORDS)))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        addr_next      = addr_reg;
        pend_w_next    = pend_w_reg;
        rel_w_next     = rel_w_reg;
        rel_b_next     = rel_b_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_id_next    = rsp_id_reg;
        rsp_st_next    = rsp_st_reg;
        rd_addr        = addr_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_w_reg;
        wr_data        = eff_word | ffz_onehot;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (op == OP_ALLOC)
                    begin
                        // start the scan at word 0
                        rd_addr     = '0;
                        pend_w_next = '0;
                        addr_next   = CNT_W'(1);
                    end
                    else
                    begin
                        rd_addr     = ADDR_W'(rel_idx >> BIT_W);
                        rel_w_next  = ADDR_W'(rel_idx >> BIT_W);
                        rel_b_next  = rel_idx[BIT_W-1:0];
                        res_id_next = '0;
                        res_st_next = STATUS_BAD_RELEASE;
                    end
                end
            end
            ST_REL_CHK:
            begin
                // clear the bit only if it was set
                wr_addr = rel_w_reg;
                wr_data = eff_word & ~rel_bit;
                if ((eff_word & rel_bit) != '0)
                begin
                    wr_en       = 1'b1;
                    res_st_next = STATUS_OK;
                end
            end
            ST_SCAN:
            begin
                if (ffz_found)
                begin
                    wr_en       = 1'b1;
                    res_id_next = ID_W'(alloc_sum);
                    res_st_next = STATUS_OK;
                end
                else if (addr_reg == CNT_W'(MAP_WORDS))
                begin
                    res_id_next = '0;
                    res_st_next = STATUS_FULL;
                end
                else
                begin
                    // fetch the next word
                    pend_w_next = addr_reg[ADDR_W-1:0];
                    addr_next   = addr_reg + CNT_W'(1);
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_id_next    = res_id_reg;
                    rsp_st_next    = res_st_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            row_vld_reg   <= '0;
            q_vld_reg     <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            q_vld_reg     <= row_vld_reg[rd_addr];
            addr_reg      <= addr_next;
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_w_reg <= pend_w_next;
        rel_w_reg  <= rel_w_next;
        rel_b_reg  <= rel_b_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
        rsp_id_reg <= rsp_id_next;
        rsp_st_reg <= rsp_st_next;
    end

    // checks
    `BIDA_ASSERT_IMP(a_wr_state, wr_en, (state_reg == ST_REL_CHK) || (state_reg == ST_SCAN), "map write outside check or scan")
    `BIDA_ASSERT_IMP(a_addr_range, state_reg == ST_SCAN, addr_reg <= CNT_W'(MAP_WORDS), "scan address past map")
    `BIDA_ASSERT_NXT(a_rsp_load, (state_reg == ST_RESP) && rsp_free, rsp_valid && (state_reg == ST_IDLE), "result not loaded")
    `BIDA_ASSERT_IMP(a_full_id, rsp_valid && (status != STATUS_OK), given_id == '0, "nonzero id with error status")

endmodule

// ----- tb/bida_grant_checker.sv -----
// checker for the bitmap id allocator: watches the request and response channels,
// predicts each grant from its own copy of the used-id map and compares in order
// depends on bida_pkg
module bida_grant_checker
    import bida_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  logic            op,
    input  logic [ID_W-1:0] release_id,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  logic [ID_W-1:0] given_id,
    input  logic [ST_W-1:0] status,
    output int              fail_count,
    output int              grants_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ST_W-1:0] st;
    } grant_t;

    // shadow of the used-id map, bit b of word w is id w*64+b+1
    logic [WORD_W-1:0] id_map [MAP_WORDS];
    grant_t            pending_grants [$];
    int                errs = 0;

    // lowest free id is taken, pool full when none is left
    function automatic grant_t predict_allocate();
        grant_t g;
        bit     found;
        int     idx;
        g.id  = '0;
        g.st  = STATUS_FULL;
        found = 1'b0;
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            if (!found && id_map[w] != {WORD_W{1'b1}})
            begin
                for (int b = 0; b < WORD_W; b++)
                begin
                    idx = w * WORD_W + b;
                    if (!found && idx < MAX_IDS && !id_map[w][b])
                    begin
                        id_map[w][b] = 1'b1;
                        g.id  = ID_W'(idx + 1);
                        g.st  = STATUS_OK;
                        found = 1'b1;
                    end
                end
            end
        end
        return g;
    endfunction

    // release clears a used id, anything else is refused and the map stays
    function automatic grant_t predict_release(input logic [ID_W-1:0] id);
        grant_t g;
        int     idx;
        g.id = '0;
        g.st = STATUS_BAD_RELEASE;
        if (id != '0 && int'(id) <= MAX_IDS)
        begin
            idx = int'(id) - 1;
            if (id_map[idx / WORD_W][idx % WORD_W])
            begin
                id_map[idx / WORD_W][idx % WORD_W] = 1'b0;
                g.st = STATUS_OK;
            end
        end
        return g;
    endfunction

    // compare accepted responses, then predict accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        grant_t exp_g;
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
                id_map[w] = '0;
            pending_grants.delete();
            grants_pending <= 0;
        end
        else
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (pending_grants.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t: unexpected response word id %0d status %0d",
                                 $realtime, given_id, status);
                    errs++;
                end
                else
                begin
                    exp_g = pending_grants.pop_front();
                    if (given_id !== exp_g.id || status !== exp_g.st)
                    begin
                        if (errs < 10)
                            $display("%0t: mismatch expected id %0d status %0d, got id %0d status %0d",
                                     $realtime, exp_g.id, exp_g.st, given_id, status);
                        errs++;
                    end
                end
            end
            if (req_valid === 1'b1 && req_stall === 1'b0)
            begin
                if (op == OP_ALLOC)
                    pending_grants.push_back(predict_allocate());
                else
                    pending_grants.push_back(predict_release(release_id));
            end
            grants_pending <= pending_grants.size();
            fail_count     <= errs;
        end
    end

endmodule

// ----- tb/bitmap_id_allocator_core_tb.sv -----
// top of the bitmap id allocator testbench: clock, reset, request stimulus,
// response back-pressure and the final verdict
// depends on bida_pkg, bitmap_id_allocator_core and bida_grant_checker
module bitmap_id_allocator_core_tb;
    import bida_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = MAP_WORDS + 8;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            req_valid  = 1'b0;
    logic            op         = OP_ALLOC;
    logic [ID_W-1:0] release_id = '0;
    logic            rsp_stall  = 1'b0;
    logic            req_stall;
    logic            rsp_valid;
    logic [ID_W-1:0] given_id;
    logic [ST_W-1:0] status;
    int              fail_count;
    int              grants_pending;

    bit quiet    = 1'b0;
    int used_est = 0;
    int hold     = 0;

    always #4 clk = ~clk;

    bitmap_id_allocator_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .op         (op),
        .release_id (release_id),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .given_id   (given_id),
        .status     (status)
    );

    bida_grant_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .release_id     (release_id),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .given_id       (given_id),
        .status         (status),
        .fail_count     (fail_count),
        .grants_pending (grants_pending)
    );

    // response back-pressure: random stall bursts between free stretches
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            rsp_stall <= 1'b0;
            hold      <= 0;
        end
        else if (hold != 0)
            hold <= hold - 1;
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp_stall <= 1'b1;
            hold      <= $urandom_range(0, 17);
        end
        else
        begin
            rsp_stall <= 1'b0;
            hold      <= $urandom_range(0, 30);
        end
    end

    // present one request word, hold it until accepted, then maybe idle
    task automatic send_word(input logic o, input logic [ID_W-1:0] id);
        req_valid  <= 1'b1;
        op         <= o;
        release_id <= id;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding grant has come back
    task automatic drain_grants();
        req_valid <= 1'b0;
        @(posedge clk);
        while (grants_pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // one random word: an allocate or a release, releases mostly near the dense low end, some noise
    task automatic random_word(input int alloc_pct);
        int              r;
        logic [ID_W-1:0] id;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            send_word(OP_ALLOC, ID_W'($urandom));
            if (used_est < MAX_IDS)
                used_est++;
        end
        else
        begin
            if (r < 8)
                id = ID_W'($urandom);
            else if (r < 11)
                id = '0;
            else
                id = ID_W'($urandom_range(1, used_est + 8));
            if (id != '0 && int'(id) <= used_est)
                used_est--;
            send_word(OP_RELEASE, id);
        end
    endtask

    // run-away guard
    initial
    begin
        #25_000_000;
        $display("[bitmap_id_allocator_core] ERROR");
        $finish;
    end

    initial
    begin
        int alloc_pct [6] = '{70, 50, 85, 25, 60, 40};
        int wait_cnt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad releases on an empty map: zero, free ids, above range, all ones
        send_word(OP_RELEASE, ID_W'(0));
        send_word(OP_RELEASE, ID_W'(1));
        send_word(OP_RELEASE, ID_W'(MAX_IDS));
        send_word(OP_RELEASE, ID_W'(MAX_IDS + 1));
        send_word(OP_RELEASE, {ID_W{1'b1}});
        // lowest-free allocation and reuse of a released hole
        send_word(OP_ALLOC, ID_W'(0));
        send_word(OP_ALLOC, {ID_W{1'b1}});
        send_word(OP_ALLOC, ID_W'(0));
        send_word(OP_RELEASE, ID_W'(2));
        send_word(OP_RELEASE, ID_W'(2));
        send_word(OP_ALLOC, ID_W'(0));
        send_word(OP_RELEASE, ID_W'(1));
        send_word(OP_RELEASE, ID_W'(3));
        send_word(OP_RELEASE, ID_W'(2));
        send_word(OP_ALLOC, ID_W'(0));
        send_word(OP_RELEASE, ID_W'(1));
        drain_grants();

        // random traffic from a nearly empty map
        used_est = 0;
        foreach (alloc_pct[s])
        begin
            repeat (130) random_word(alloc_pct[s]);
            drain_grants();
        end

        // random traffic on the grown map, last stretch without idling
        foreach (alloc_pct[s])
        begin
            if (s == 5)
                quiet = 1'b1;
            repeat (125) random_word(100 - alloc_pct[s]);
        end

        // wait for the last grants, bounded
        req_valid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (grants_pending != 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (LATENCY) @(posedge clk);

        if (fail_count == 0 && grants_pending == 0)
            $display("[bitmap_id_allocator_core] OK");
        else
            $display("[bitmap_id_allocator_core] ERROR");
        $finish;
    end

endmodule
